/* rtl/mipmapped_wavetable_oscillator_macros.svh */
// Assertion macros for the mipmapped wavetable oscillator.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef MIPMAPPED_WAVETABLE_OSCILLATOR_MACROS_SVH
`define MIPMAPPED_WAVETABLE_OSCILLATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define MWO_ASSERT(lbl, prop, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define MWO_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define MWO_ASSERT(lbl, prop, msg)
`define MWO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/mwo_pkg.sv */
// Package for the mipmapped wavetable oscillator: sequencer states, widths
// and the fixed-point blend function. No dependencies.
`default_nettype none
package mwo_pkg;
   localparam int TABLE_AW = 15;
   localparam int MIP_W    = 4;
   localparam int LVL_W    = 6;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_LOG, ST_NORM, ST_READ, ST_MIX1, ST_MIX2, ST_DONE
   } state_type;

   // a + floor((b - a) * w / 65536); the result always lies between a and b.
   function automatic logic signed [15:0] blend(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic [15:0] w);
      logic signed [16:0] d;
      logic signed [33:0] prod;
      logic signed [17:0] sh;
      d    = 17'(b) - 17'(a);
      prod = 34'(d) * 34'($signed({1'b0, w}));
      sh   = 18'(prod >>> 16);
      return 16'(18'(a) + sh);
   endfunction
endpackage
`default_nettype wire

/* rtl/mipmapped_wavetable_oscillator.sv */
// Top level of the mipmapped wavetable oscillator: table memory, phase
// accumulator and read sequencer. Depends on mwo_pkg and the macros header.
//
// Channel | Direction | Contents
// req_    | in        | tuser: kind; tdata: table_address, table_value, level, frequency
// rsp_    | out       | tdata: sample_out
// csr_    | in        | csr_data: hz_to_phase
//
// A load transfer writes the table directly when it is accepted.
// A sample transfer passes through one multiply, a leading-one search, a
// normalisation, eight reads on the single table port, and the blend steps
// ST_MIX1 and ST_MIX2 before its result is valid. Reset clears the
// sequencer, the phase, the read counter and the result valid flag; the
// table contents stay undefined until loaded. A waiting result does not block the
// next one, but a second result waits in ST_DONE until the first is taken.
`default_nettype none
`include "mipmapped_wavetable_oscillator_macros.svh"
module mipmapped_wavetable_oscillator #(
   parameter int MIP_COUNT   = 12,
   parameter int LEVEL_COUNT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] kind
   input  wire logic [0:0]  req_tuser,
   // [14:0] table_address, [30:15] table_value, [46:31] level,
   // [70:47] frequency, [71] zero
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] sample_out
   output logic [15:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);
   localparam int TAW = mwo_pkg::TABLE_AW;
   localparam int MW  = mwo_pkg::MIP_W;
   localparam int LW  = mwo_pkg::LVL_W;

   logic [31:0] hz_ff;
   logic [31:0] phase_ff;
   mwo_pkg::state_type state_ff, state_in;

   logic [15:0] level_ff;
   logic [55:0] prod_ff;
   logic [39:0] inc_ff;
   logic [5:0]  pos_ff;
   logic        zero_ff;
   logic [MW-1:0] mlo_ff, mhi_ff;
   logic [15:0]   mw_ff;
   logic [LW-1:0] llo_ff, lhi_ff;
   logic [15:0]   lw_ff;
   logic [3:0]    cnt_ff;
   logic [15:0]   w_ff;
   logic signed [15:0] lo_ff, rd_data_ff;
   logic signed [15:0] r_ff [4];
   logic signed [15:0] a_ff, b_ff, y_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;

   logic [15:0] mem [2**TAW];

   logic accept;
   logic is_load;
   assign req_tready = (state_ff == mwo_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_load    = accept && !req_tuser[0];
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Leading-one position of the increment.
   logic [5:0] pos;
   always_comb begin
      pos = '0;
      for (int i = 0; i < 40; i++) begin
         if (inc_ff[i]) pos = 6'(i);
      end
   end

   // Log of the increment turned into a mip choice, and the timbre split.
   logic [39:0] norm;
   logic [15:0] frac;
   logic signed [23:0] mipq, mip_lim;
   logic [MW-1:0] mlo, mhi;
   logic [15:0]   mw;
   logic [21:0]   lvq;
   always_comb begin
      norm    = inc_ff << (6'd39 - pos_ff);
      frac    = norm[38:23];
      mipq    = $signed(24'((24'd32 - {18'd0, pos_ff}) << 16) - {8'd0, frac});
      mip_lim = $signed(24'((MIP_COUNT - 1) << 16));
      if (zero_ff || mipq >= mip_lim) begin
         mlo = MW'(MIP_COUNT - 1);
         mhi = MW'(MIP_COUNT - 1);
         mw  = '0;
      end else if (mipq < 0) begin
         mlo = '0;
         mhi = '0;
         mw  = '0;
      end else begin
         mlo = mipq[16 +: MW];
         mw  = mipq[15:0];
         mhi = (mw != 16'd0) ? MW'(mlo + 1'b1) : mlo;
      end
      lvq = 22'(level_ff * 16'(LEVEL_COUNT - 1));
   end

   // Address and weight for the read about to be issued.
   logic [1:0]     pair;
   logic [MW-1:0]  rm;
   logic [LW-1:0]  rl;
   logic [TAW-1:0] mask, idx_lo, idx_hi, base, raddr;
   logic [31:0]    pshift;
   logic [15:0]    wgt;
   always_comb begin
      pair   = cnt_ff[2:1];
      rm     = pair[0] ? mhi_ff : mlo_ff;
      rl     = pair[1] ? lhi_ff : llo_ff;
      mask   = TAW'((16'd1 << rm) - 16'd1);
      idx_lo = TAW'({15'd0, phase_ff} >> (6'd32 - {2'd0, rm})) & mask;
      idx_hi = TAW'(idx_lo + 1'b1) & mask;
      base   = TAW'({rl[2:0], 12'd0}) + mask;
      raddr  = TAW'(base + (cnt_ff[0] ? idx_hi : idx_lo));
      pshift = phase_ff << rm;
      wgt    = pshift[31:16];
   end

   logic [3:0] prev;
   assign prev = cnt_ff - 4'd1;

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= mwo_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mwo_pkg::ST_IDLE: if (accept && req_tuser[0]) state_in = mwo_pkg::ST_MUL;
         mwo_pkg::ST_MUL:  state_in = mwo_pkg::ST_LOG;
         mwo_pkg::ST_LOG:  state_in = mwo_pkg::ST_NORM;
         mwo_pkg::ST_NORM: state_in = mwo_pkg::ST_READ;
         mwo_pkg::ST_READ: if (cnt_ff == 4'd8) state_in = mwo_pkg::ST_MIX1;
         mwo_pkg::ST_MIX1: state_in = mwo_pkg::ST_MIX2;
         mwo_pkg::ST_MIX2: state_in = mwo_pkg::ST_DONE;
         mwo_pkg::ST_DONE: if (!rsp_valid_ff || rsp_tready) state_in = mwo_pkg::ST_IDLE;
         default:          state_in = mwo_pkg::ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hz_ff        <= 32'd24932236;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) hz_ff <= csr_data;
         if (state_ff == mwo_pkg::ST_LOG) phase_ff <= phase_ff + inc_ff[31:0];
         if (state_ff == mwo_pkg::ST_READ && cnt_ff != 4'd8) cnt_ff <= cnt_ff + 4'd1;
         else                                                cnt_ff <= '0;
         if (state_ff == mwo_pkg::ST_DONE && (!rsp_valid_ff || rsp_tready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers. The product is taken as the transfer is accepted and
   // each following stage holds its result until the next sample.
   always_ff @(posedge clock) begin
      if (accept) begin
         level_ff <= req_tdata[46:31];
         prod_ff  <= {32'd0, req_tdata[70:47]} * {24'd0, hz_ff};
      end
      if (state_ff == mwo_pkg::ST_MUL) inc_ff <= prod_ff[55:16];
      if (state_ff == mwo_pkg::ST_LOG) begin
         pos_ff  <= pos;
         zero_ff <= (inc_ff == 40'd0);
      end
      if (state_ff == mwo_pkg::ST_NORM) begin
         mlo_ff <= mlo;
         mhi_ff <= mhi;
         mw_ff  <= mw;
         llo_ff <= lvq[21:16];
         lhi_ff <= (lvq[15:0] != 16'd0) ? LW'(lvq[21:16] + 1'b1) : lvq[21:16];
         lw_ff  <= lvq[15:0];
      end
      if (state_ff == mwo_pkg::ST_READ) begin
         w_ff <= wgt;
         if (cnt_ff != 4'd0) begin
            if (!prev[0]) lo_ff <= rd_data_ff;
            else          r_ff[prev[2:1]] <= mwo_pkg::blend(lo_ff, rd_data_ff, w_ff);
         end
      end
      if (state_ff == mwo_pkg::ST_MIX1) begin
         a_ff <= mwo_pkg::blend(r_ff[0], r_ff[1], mw_ff);
         b_ff <= mwo_pkg::blend(r_ff[2], r_ff[3], mw_ff);
      end
      if (state_ff == mwo_pkg::ST_MIX2) y_ff <= mwo_pkg::blend(a_ff, b_ff, lw_ff);
      if (state_ff == mwo_pkg::ST_DONE && (!rsp_valid_ff || rsp_tready))
         rsp_data_ff <= y_ff;
   end

   // Single-port table: a load writes, the sequencer reads.
   always_ff @(posedge clock) begin
      if (is_load) mem[req_tdata[14:0]] <= req_tdata[30:15];
      rd_data_ff <= mem[raddr];
   end

   `MWO_ASSERT(a_cnt_range, cnt_ff <= 4'd8, "read counter overran")
   `MWO_ASSERT_NEXT(a_sample_start, accept && req_tuser[0], state_ff == mwo_pkg::ST_MUL,
                    "sample transfer did not start the sequencer")
   `MWO_ASSERT_NEXT(a_read_end, state_ff == mwo_pkg::ST_READ && cnt_ff == 4'd8,
                    state_ff == mwo_pkg::ST_MIX1, "read phase did not end after eight reads")
   `MWO_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(state_ff == mwo_pkg::ST_DONE),
               "result appeared outside the final stage")
endmodule
`default_nettype wire
